@@ rtl/dnsp_pkg.sv @@
// Shared types and constants for the DNS answer record parser.
// Used by dnsp_step and dns_answer_record_parser; depends on nothing else.
package dnsp_pkg;

   // Byte position within a record header; this value means inside the rdata.
   localparam logic [3:0] POS_TYPE_HI  = 4'd2;
   localparam logic [3:0] POS_TYPE_LO  = 4'd3;
   localparam logic [3:0] POS_RDLEN_HI = 4'd10;
   localparam logic [3:0] POS_RDLEN_LO = 4'd11;
   localparam logic [3:0] POS_RDATA    = 4'd12;

   // Record type codes and the type high byte that both accepted types share.
   localparam logic [7:0] TYPE_HI_ZERO = 8'h00;
   localparam logic [7:0] TYPE_A       = 8'h01;
   localparam logic [7:0] TYPE_CNAME   = 8'h05;

   // Number of rdata bytes that form an IPv4 address.
   localparam logic [2:0] ADDR_BYTES = 3'd4;

   // Result kind codes.
   localparam logic RESULT_A     = 1'b0;
   localparam logic RESULT_CNAME = 1'b1;

   typedef enum logic [1:0] {
      KIND_SKIP    = 2'd0,
      KIND_A       = 2'd1,
      KIND_CNAME   = 2'd2,
      KIND_PENDING = 2'd3
   } kind_type;

   // Parser state carried from one byte to the next.
   typedef struct packed {
      logic [3:0]  field_position;
      logic [15:0] rdata_remaining;
      kind_type    record_kind;
      logic [31:0] address_shift;
      logic [2:0]  rdata_bytes_seen;
      logic [15:0] answers_remaining;
      logic [15:0] current_answer;
   } state_type;

   // One result item.
   typedef struct packed {
      logic        valid;
      logic        record_kind;
      logic [15:0] answer_index;
      logic [31:0] address;
      logic [7:0]  name_byte;
      logic        last;
   } result_type;

endpackage

@@ rtl/dnsp_step.sv @@
// Combinational next-state and result logic for one answer-section byte.
// Depends on dnsp_pkg for the state and result types.
module dnsp_step (
   input  dnsp_pkg::state_type  state_cur,
   input  logic [7:0]           data_byte,
   input  logic                 first,
   input  logic [15:0]          answer_count,
   output dnsp_pkg::state_type  state_next,
   output dnsp_pkg::result_type result
);

   always_comb begin
      dnsp_pkg::state_type s;
      logic                end_rec;
      logic [15:0]         rem_dec;
      logic [31:0]         addr_new;

      s        = state_cur;
      end_rec  = 1'b0;
      rem_dec  = state_cur.rdata_remaining - 16'd1;
      addr_new = {state_cur.address_shift[23:0], data_byte};
      result   = '0;

      // A first byte restarts the section with a fresh record.
      if (first) begin
         s.field_position    = '0;
         s.rdata_remaining   = '0;
         s.record_kind       = dnsp_pkg::KIND_SKIP;
         s.address_shift     = '0;
         s.rdata_bytes_seen  = '0;
         s.answers_remaining = answer_count;
         s.current_answer    = '0;
      end

      // Walk the record only while answers remain.
      if (s.answers_remaining != 16'd0) begin
         unique case (s.field_position)
            dnsp_pkg::POS_TYPE_HI: begin
               s.record_kind    = (data_byte == dnsp_pkg::TYPE_HI_ZERO) ?
                                  dnsp_pkg::KIND_PENDING : dnsp_pkg::KIND_SKIP;
               s.field_position = s.field_position + 4'd1;
            end
            dnsp_pkg::POS_TYPE_LO: begin
               if (s.record_kind == dnsp_pkg::KIND_PENDING) begin
                  if (data_byte == dnsp_pkg::TYPE_A) begin
                     s.record_kind = dnsp_pkg::KIND_A;
                  end else if (data_byte == dnsp_pkg::TYPE_CNAME) begin
                     s.record_kind = dnsp_pkg::KIND_CNAME;
                  end else begin
                     s.record_kind = dnsp_pkg::KIND_SKIP;
                  end
               end else begin
                  s.record_kind = dnsp_pkg::KIND_SKIP;
               end
               s.field_position = s.field_position + 4'd1;
            end
            dnsp_pkg::POS_RDLEN_HI: begin
               s.rdata_remaining = {data_byte, 8'h00};
               s.field_position  = s.field_position + 4'd1;
            end
            dnsp_pkg::POS_RDLEN_LO: begin
               s.rdata_remaining = {s.rdata_remaining[15:8], data_byte};
               if ({s.rdata_remaining[15:8], data_byte} == 16'd0) begin
                  end_rec = 1'b1;
               end else begin
                  s.field_position = dnsp_pkg::POS_RDATA;
               end
            end
            dnsp_pkg::POS_RDATA: begin
               // Inside the rdata: count down and emit per record kind.
               s.rdata_remaining = rem_dec;
               if (s.record_kind == dnsp_pkg::KIND_A) begin
                  if (s.rdata_bytes_seen < dnsp_pkg::ADDR_BYTES) begin
                     s.address_shift    = addr_new;
                     s.rdata_bytes_seen = s.rdata_bytes_seen + 3'd1;
                     if (s.rdata_bytes_seen == dnsp_pkg::ADDR_BYTES) begin
                        result.valid        = 1'b1;
                        result.record_kind  = dnsp_pkg::RESULT_A;
                        result.answer_index = s.current_answer;
                        result.address      = addr_new;
                        result.last         = 1'b1;
                     end
                  end
               end else if (s.record_kind == dnsp_pkg::KIND_CNAME) begin
                  result.valid        = 1'b1;
                  result.record_kind  = dnsp_pkg::RESULT_CNAME;
                  result.answer_index = s.current_answer;
                  result.name_byte    = data_byte;
                  result.last         = (rem_dec == 16'd0);
               end
               end_rec = (rem_dec == 16'd0);
            end
            default: begin
               s.field_position = s.field_position + 4'd1;
            end
         endcase

         // Close the record and move on to the next one.
         if (end_rec) begin
            s.answers_remaining = s.answers_remaining - 16'd1;
            s.current_answer    = s.current_answer + 16'd1;
            s.field_position    = '0;
            s.rdata_remaining   = '0;
            s.record_kind       = dnsp_pkg::KIND_SKIP;
            s.address_shift     = '0;
            s.rdata_bytes_seen  = '0;
         end
      end

      state_next = s;
   end

endmodule

@@ rtl/dns_answer_record_parser.sv @@
// Top level of the DNS answer record parser: state and result registers.
// Depends on dnsp_pkg and dnsp_step.
//
// Usage: the req_ channel carries the answer section one byte per transfer.
// req_first marks the first byte of a section and samples req_answer_count.
// Each record is a 2-byte name, type, class, TTL, 16-bit rdata length and
// the rdata. A records with four or more rdata bytes give one rsp_ transfer
// with the address; CNAME records give one rsp_ transfer per rdata byte,
// rsp_last on the final one. Other records are walked over and give nothing.
// A result appears in the rsp_ register in the cycle after the byte that
// causes it is transferred. Throughput: one byte per cycle while rsp_ready
// allows, set by the single registered pass of the header/rdata counter logic.
// The block takes a new byte while a result is being taken, so it keeps
// full rate as long as rsp_ready is high; while a result waits with
// rsp_ready low, req_ready drops and the byte stream holds.
// Reset (synchronous, active high) clears the parser to idle and empties
// the result register; bytes without req_first are ignored while idle.
module dns_answer_record_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   input  logic [15:0] req_answer_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_kind,
   output logic [15:0] rsp_answer_index,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_name_byte,
   output logic        rsp_last
);

   dnsp_pkg::state_type  state_ff;
   dnsp_pkg::state_type  state_in;
   dnsp_pkg::result_type result_step;
   dnsp_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 req_xfer;

   // Accept a byte whenever the result register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   dnsp_step u_step (
      .state_cur    (state_ff),
      .data_byte    (req_data_byte),
      .first        (req_first),
      .answer_count (req_answer_count),
      .state_next   (state_in),
      .result       (result_step)
   );

   // Parser state advances on every input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // Result register: load on input transfer, clear valid when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= result_step.valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= result_step;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_kind  = rsp_ff.record_kind;
   assign rsp_answer_index = rsp_ff.answer_index;
   assign rsp_address      = rsp_ff.address;
   assign rsp_name_byte    = rsp_ff.name_byte;
   assign rsp_last         = rsp_ff.last;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for dns_answer_record_parser.
// Predicts each answer result from the byte stream and checks every rsp_ transfer.
// Depends on dnsp_pkg and the dns_answer_record_parser RTL.

// One expected or observed answer result.
typedef struct packed {
   logic        rec_kind;
   logic [15:0] rec_index;
   logic [31:0] address;
   logic [7:0]  name_byte;
   logic        last;
} answer_type;

// Tracks the parser state from accepted bytes and holds the answers still due.
class answer_tracker;
   logic [3:0]        pos;
   logic [15:0]       rd_left;
   dnsp_pkg::kind_type kind;
   logic [31:0]       addr_acc;
   logic [2:0]        addr_cnt;
   logic [15:0]       ans_left;
   logic [15:0]       ans_idx;
   answer_type        pending_answers[$];
   int                mismatch_count;

   function new();
      start_record();
      ans_left = '0;
      ans_idx = '0;
      mismatch_count = 0;
   endfunction

   function void start_record();
      pos = '0;
      rd_left = '0;
      kind = dnsp_pkg::KIND_SKIP;
      addr_acc = '0;
      addr_cnt = '0;
   endfunction

   function void close_record();
      ans_left = ans_left - 16'd1;
      ans_idx = ans_idx + 16'd1;
      start_record();
   endfunction

   function int pending_count();
      return pending_answers.size();
   endfunction

   // Advance the parser by one accepted byte and queue any answer it gives.
   function void note_byte(logic [7:0] b, logic lead, logic [15:0] count);
      answer_type ans;
      if (lead) begin
         start_record();
         ans_left = count;
         ans_idx = '0;
      end
      if (ans_left == 16'd0) return;
      case (pos)
         dnsp_pkg::POS_TYPE_HI: begin
            kind = (b == dnsp_pkg::TYPE_HI_ZERO) ? dnsp_pkg::KIND_PENDING
                                                 : dnsp_pkg::KIND_SKIP;
            pos++;
         end
         dnsp_pkg::POS_TYPE_LO: begin
            if (kind == dnsp_pkg::KIND_PENDING)
               kind = (b == dnsp_pkg::TYPE_A) ? dnsp_pkg::KIND_A
                    : (b == dnsp_pkg::TYPE_CNAME) ? dnsp_pkg::KIND_CNAME
                    : dnsp_pkg::KIND_SKIP;
            else
               kind = dnsp_pkg::KIND_SKIP;
            pos++;
         end
         dnsp_pkg::POS_RDLEN_HI: begin
            rd_left = {b, 8'h00};
            pos++;
         end
         dnsp_pkg::POS_RDLEN_LO: begin
            rd_left = {rd_left[15:8], b};
            if (rd_left == 16'd0) close_record();
            else pos = dnsp_pkg::POS_RDATA;
         end
         dnsp_pkg::POS_RDATA: begin
            // Inside the rdata: A gathers four bytes, CNAME passes each byte on.
            rd_left = rd_left - 16'd1;
            if (kind == dnsp_pkg::KIND_A && addr_cnt < dnsp_pkg::ADDR_BYTES) begin
               addr_acc = {addr_acc[23:0], b};
               addr_cnt++;
               if (addr_cnt == dnsp_pkg::ADDR_BYTES) begin
                  ans = '{dnsp_pkg::RESULT_A, ans_idx, addr_acc, 8'h00, 1'b1};
                  pending_answers.push_back(ans);
               end
            end else if (kind == dnsp_pkg::KIND_CNAME) begin
               ans = '{dnsp_pkg::RESULT_CNAME, ans_idx, 32'h0, b, rd_left == 16'd0};
               pending_answers.push_back(ans);
            end
            if (rd_left == 16'd0) close_record();
         end
         default: pos++;
      endcase
   endfunction

   task report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Compare one observed answer with the oldest one still due.
   task check_answer(answer_type got);
      answer_type want;
      if (pending_answers.size() == 0) begin
         report_mismatch($sformatf("unexpected result %p", got));
         return;
      end
      want = pending_answers.pop_front();
      if (got.rec_kind !== want.rec_kind)
         report_mismatch($sformatf("record_kind %0b, want %0b", got.rec_kind, want.rec_kind));
      if (got.rec_index !== want.rec_index)
         report_mismatch($sformatf("answer_index %0d, want %0d", got.rec_index,
                                   want.rec_index));
      if (got.address !== want.address)
         report_mismatch($sformatf("address %h, want %h", got.address, want.address));
      if (got.name_byte !== want.name_byte)
         report_mismatch($sformatf("name_byte %h, want %h", got.name_byte, want.name_byte));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
   endtask
endclass

module tb_top;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int FULL_RECORD = 1000000;
   localparam int PHASE_BYTES = 480;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first = 1'b0;
   logic [15:0] req_answer_count = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_record_kind;
   logic [15:0] rsp_answer_index;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_name_byte;
   logic        rsp_last;

   answer_tracker tracker = new();
   int unsigned send_idle_pct = 38;
   int unsigned recv_idle_pct = 84;
   int          bytes_sent = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          idle_cycles = 0;

   dns_answer_record_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_first(req_first),
      .req_answer_count(req_answer_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_record_kind(rsp_record_kind),
      .rsp_answer_index(rsp_answer_index),
      .rsp_address(rsp_address),
      .rsp_name_byte(rsp_name_byte),
      .rsp_last(rsp_last)
   );

   always #10 clock = ~clock;

   // Receiver: check each result transfer, then pick the ready level for the next cycle.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            tracker.check_answer('{rsp_record_kind, rsp_answer_index, rsp_address,
                                   rsp_name_byte, rsp_last});
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one byte after a random gap and wait for its transfer.
   task automatic send_byte(input logic [7:0] b, input logic lead, input logic [15:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_first <= lead;
      req_answer_count <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_byte(b, lead, count);
      bytes_sent++;
   endtask

   // Send one record, stopping after cut bytes to model a broken record.
   task automatic send_record(input logic [7:0] thi, input logic [7:0] tlo,
                              input logic [15:0] len, input int cut,
                              input logic lead, input logic [15:0] count);
      logic [7:0] b;
      for (int i = 0; i < 12 + int'(len) && i < cut; i++) begin
         case (i)
            dnsp_pkg::POS_TYPE_HI:  b = thi;
            dnsp_pkg::POS_TYPE_LO:  b = tlo;
            dnsp_pkg::POS_RDLEN_HI: b = len[15:8];
            dnsp_pkg::POS_RDLEN_LO: b = len[7:0];
            default:                b = 8'($urandom_range(255));
         endcase
         if (lead && i == 0) send_byte(b, 1'b1, count);
         else send_byte(b, 1'b0, 16'($urandom_range(65535)));
      end
   endtask

   // Hold the byte stream until every answer due has been taken.
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // A random answer section: mostly well-formed, some cut short or with odd counts.
   task automatic send_random_section();
      int          nrec;
      int          r;
      int          count;
      int          cut;
      logic [7:0]  thi;
      logic [7:0]  tlo;
      logic [15:0] len;
      nrec = $urandom_range(1, 4);
      r = $urandom_range(99);
      if (r < 70) count = nrec;
      else if (r < 80) count = $urandom_range(0, nrec - 1);
      else if (r < 90) count = nrec + $urandom_range(1, 3);
      else count = $urandom_range(65535);
      for (int i = 0; i < nrec; i++) begin
         r = $urandom_range(99);
         if (r < 45) begin
            thi = dnsp_pkg::TYPE_HI_ZERO;
            tlo = dnsp_pkg::TYPE_A;
            r = $urandom_range(99);
            if (r < 80) len = 16'd4;
            else if (r < 99) len = 16'($urandom_range(0, 8));
            else len = 16'($urandom_range(256, 300));
         end else if (r < 80) begin
            thi = dnsp_pkg::TYPE_HI_ZERO;
            tlo = dnsp_pkg::TYPE_CNAME;
            len = 16'($urandom_range(0, 12));
         end else begin
            thi = (r < 88) ? dnsp_pkg::TYPE_HI_ZERO : 8'($urandom_range(1, 255));
            tlo = (r < 95 && r >= 88) ?
                  ($urandom_range(1) ? dnsp_pkg::TYPE_A : dnsp_pkg::TYPE_CNAME) :
                  8'($urandom_range(255));
            len = ($urandom_range(99) < 2) ? 16'($urandom_range(200, 300))
                                           : 16'($urandom_range(0, 10));
         end
         cut = ($urandom_range(99) < 6) ? $urandom_range(1, 11 + int'(len)) : FULL_RECORD;
         send_record(thi, tlo, len, cut, i == 0, 16'(count));
         if (cut != FULL_RECORD) break;
      end
      // Occasional stray bytes between sections.
      if ($urandom_range(99) < 10)
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
   endtask

   // Directed cases: idle bytes, zero count, each record kind and rdata length corner.
   task automatic run_directed();
      send_byte(8'hFF, 1'b0, 16'hFFFF);
      send_byte(8'h00, 1'b1, 16'h0000);
      send_byte(8'hFF, 1'b0, 16'h1234);
      send_record(dnsp_pkg::TYPE_HI_ZERO, dnsp_pkg::TYPE_A, 16'd4, FULL_RECORD, 1'b1, 16'd8);
      send_record(dnsp_pkg::TYPE_HI_ZERO, dnsp_pkg::TYPE_CNAME, 16'd3, FULL_RECORD, 1'b0,
                  16'd0);
      send_record(dnsp_pkg::TYPE_HI_ZERO, dnsp_pkg::TYPE_A, 16'd0, FULL_RECORD, 1'b0, 16'd0);
      send_record(dnsp_pkg::TYPE_HI_ZERO, dnsp_pkg::TYPE_CNAME, 16'd0, FULL_RECORD, 1'b0,
                  16'd0);
      send_record(dnsp_pkg::TYPE_HI_ZERO, dnsp_pkg::TYPE_A, 16'd2, FULL_RECORD, 1'b0, 16'd0);
      send_record(dnsp_pkg::TYPE_HI_ZERO, dnsp_pkg::TYPE_A, 16'd6, FULL_RECORD, 1'b0, 16'd0);
      send_record(dnsp_pkg::TYPE_HI_ZERO, 8'h02, 16'd3, FULL_RECORD, 1'b0, 16'd0);
      send_record(8'h07, dnsp_pkg::TYPE_A, 16'd2, FULL_RECORD, 1'b0, 16'd0);
      // Restart in the middle of a CNAME rdata.
      send_record(dnsp_pkg::TYPE_HI_ZERO, dnsp_pkg::TYPE_CNAME, 16'd5, 14, 1'b1, 16'd2);
      send_record(dnsp_pkg::TYPE_HI_ZERO, dnsp_pkg::TYPE_A, 16'd4, FULL_RECORD, 1'b1,
                  16'hFFFF);
      send_byte(8'h00, 1'b1, 16'h0000);
      wait_for_answers();
   endtask

   // Main sequence: reset, directed cases, then three random phases.
   initial begin
      int target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 0) begin
            send_idle_pct = 38;
            recv_idle_pct = 84;
         end else if (phase == 1) begin
            send_idle_pct = 84;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // Long receiver stall while bytes keep coming, to back up the input.
            hold_request = 1'b1;
         end
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) send_random_section();
         wait_for_answers();
      end
      repeat (8) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending_count() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

@@ files.f @@
rtl/dnsp_pkg.sv
rtl/dnsp_step.sv
rtl/dns_answer_record_parser.sv
tb/tb_top.sv
